@@ rtl/utf8_stream_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_defines
// Assertion macros used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define U8SD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and byte-class constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POINT_W = 21;
   localparam int unsigned LEN_W   = 3;

   // Byte classes
   localparam logic [BYTE_W-1:0] END_OF_STRING = 8'h00;
   localparam logic [BYTE_W-1:0] ASCII_LO      = 8'h01;
   localparam logic [BYTE_W-1:0] ASCII_HI      = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD2_LO      = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD2_HI      = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LO      = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI      = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LO      = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI      = 8'hF7;
   localparam logic [1:0]        CONT_TAG      = 2'b10;

   localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

   typedef struct packed {
      logic [1:0]         bytes_pending;
      logic [POINT_W-1:0] partial_point;
      logic [LEN_W-1:0]   sequence_length;
      logic               dropping_rest;
   } dec_state_type;

   typedef struct packed {
      logic               emit;
      logic [POINT_W-1:0] code_point;
      logic [LEN_W-1:0]   byte_length;
   } dec_result_type;

endpackage

`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming NUL-terminated UTF-8 decoder, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte per transaction (req_valid / req_stall).
//   rsp channel: one decoded code point and its byte length per transaction
//   (rsp_valid / rsp_stall). Only the byte that finishes a sequence (or an
//   ASCII byte) produces a rsp transaction; other bytes produce none.
//   An accepted byte is held in the input register; the decoder state and
//   the result register then update from it, and its code point is on rsp_*.
//   Throughput: one byte per cycle unless rsp_stall holds a result; input and
//   result registers form a two-stage pipeline, one state update per byte.
//   A 0x00 byte ends the string and clears all state; after a malformed
//   byte no code point is produced until the next 0x00.
//   Reset clears the valid flags of both pipeline registers and the state.
//   When the receiver stalls with a result pending, the input register
//   holds its byte and req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [u8sd_pkg::BYTE_W-1:0]  req_text_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [u8sd_pkg::POINT_W-1:0]      rsp_code_point,
   output logic [u8sd_pkg::LEN_W-1:0]        rsp_byte_length
);
   import u8sd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff,  in_byte_in;
   dec_state_type      state_ff,    state_in;
   logic               out_valid_ff, out_valid_in;
   logic [POINT_W-1:0] out_point_ff, out_point_in;
   logic [LEN_W-1:0]   out_len_ff,   out_len_in;

   dec_state_type  step_state;
   dec_result_type step_result;
   logic           out_free;
   logic           advance;

   u8sd_step u_step (
      .text_byte  (in_byte_ff),
      .state      (state_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_point_in = out_point_ff;
      out_len_in   = out_len_ff;

      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_text_byte;
      end

      if (advance) begin
         state_in     = step_state;
         out_valid_in = step_result.emit;
         if (step_result.emit) begin
            out_point_in = step_result.code_point;
            out_len_in   = step_result.byte_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_point_ff <= out_point_in;
      out_len_ff   <= out_len_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_point_ff;
   assign rsp_byte_length = out_len_ff;

   `U8SD_ASSERT_NOW(a_pending_not_dropping, clock, reset,
      state_ff.bytes_pending != 2'd0, !state_ff.dropping_rest,
      "sequence in progress while dropping")

   `U8SD_ASSERT_NOW(a_pending_matches_length, clock, reset,
      state_ff.bytes_pending != 2'd0,
      state_ff.sequence_length > LEN_W'(state_ff.bytes_pending),
      "pending count exceeds sequence length")

   `U8SD_ASSERT_NOW(a_length_range, clock, reset,
      out_valid_ff, (out_len_ff >= LEN_1) && (out_len_ff <= LEN_4),
      "result byte length out of range")

   `U8SD_ASSERT_NEXT(a_nul_clears, clock, reset,
      advance && (in_byte_ff == END_OF_STRING), state_ff == '0,
      "end of string did not clear state")

   `U8SD_ASSERT_NEXT(a_hold_when_blocked, clock, reset,
      in_valid_ff && !out_free, in_valid_ff && $stable(in_byte_ff) && $stable(state_ff),
      "blocked byte or state changed")

endmodule

`default_nettype wire

@@ rtl/u8sd_step.sv @@
// ----------------------------------------------------------------------------
// u8sd_step
// Next decoder state and optional code point for one text byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8sd_step (
   input  wire logic [u8sd_pkg::BYTE_W-1:0] text_byte,
   input  wire u8sd_pkg::dec_state_type     state,
   output u8sd_pkg::dec_state_type          state_next,
   output u8sd_pkg::dec_result_type         result
);
   import u8sd_pkg::*;

   logic [POINT_W-1:0] shifted_point;
   logic [1:0]         pending_next;

   assign shifted_point = {state.partial_point[POINT_W-7:0], text_byte[5:0]};
   assign pending_next  = state.bytes_pending - 2'd1;

   always_comb begin
      state_next         = state;
      result.emit        = 1'b0;
      result.code_point  = shifted_point;
      result.byte_length = state.sequence_length;

      if (text_byte == END_OF_STRING) begin
         state_next = '0;
      end else if (state.dropping_rest) begin
         state_next = state;
      end else if (state.bytes_pending != 2'd0) begin
         if (text_byte[7:6] != CONT_TAG) begin
            state_next               = '0;
            state_next.dropping_rest = 1'b1;
         end else if (pending_next == 2'd0) begin
            // last continuation: emit and close the sequence
            result.emit = 1'b1;
            state_next  = '0;
         end else begin
            state_next.partial_point = shifted_point;
            state_next.bytes_pending = pending_next;
         end
      end else begin
         case (text_byte) inside
            [ASCII_LO:ASCII_HI]: begin
               result.emit        = 1'b1;
               result.code_point  = POINT_W'(text_byte);
               result.byte_length = LEN_1;
            end
            [LEAD2_LO:LEAD2_HI]: begin
               state_next.sequence_length = LEN_2;
               state_next.partial_point   = POINT_W'(text_byte[4:0]);
               state_next.bytes_pending   = 2'd1;
            end
            [LEAD3_LO:LEAD3_HI]: begin
               state_next.sequence_length = LEN_3;
               state_next.partial_point   = POINT_W'(text_byte[3:0]);
               state_next.bytes_pending   = 2'd2;
            end
            [LEAD4_LO:LEAD4_HI]: begin
               state_next.sequence_length = LEN_4;
               state_next.partial_point   = POINT_W'(text_byte[2:0]);
               state_next.bytes_pending   = 2'd3;
            end
            default: begin
               // stray continuation or invalid lead
               state_next               = '0;
               state_next.dropping_rest = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Sends a short directed set of byte strings and then random strings, most of
// them well-formed and some with corrupted, missing or stray bytes. A local
// decoder model predicts each code point as its byte is accepted. A monitor
// compares every rsp transaction with the oldest prediction. Both channels
// idle in random bursts. The receiver holds off for a long stretch once, and
// the sender pauses between the two phases until the decoder is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import u8sd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [BYTE_W-1:0] req_text_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [POINT_W-1:0] rsp_code_point;
   logic [LEN_W-1:0] rsp_byte_length;

   utf8_stream_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_length (rsp_byte_length)
   );

   always #5 clock = ~clock;

   logic [BYTE_W-1:0] outgoing_text [$];
   dec_result_type    pending_points [$];
   dec_state_type     decoder_state = '0;

   int  bytes_loaded = 0;
   int  bytes_taken = 0;
   int  points_checked = 0;
   int  strings_built = 0;
   int  input_stall_cycles = 0;
   int  mismatches = 0;
   bit  random_loaded = 1'b0;
   bit  tail_calm = 1'b0;

   int  tx_gap = 0;
   int  tx_rate = 4;
   int  tx_cycle = 0;
   int  rx_gap = 0;
   int  rx_rate = 4;
   int  rx_cycle = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   // Directed strings: extremes of 1-, 2- and 3-byte sequences, the top 4-byte one, then
   // NUL inside a sequence, bad lead with ignored bytes, bad continuation, and recovery.
   logic [BYTE_W-1:0] opening_text [25] = '{
      8'h01, 8'h7F,
      8'hC0, 8'h80, 8'hDF, 8'hBF,
      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'hE2, 8'h00,
      8'hFF, 8'h41, 8'h00,
      8'hC3, 8'h41, 8'h00,
      8'h41
   };

   // Advance the local decoder by one byte; return the code point it yields.
   function automatic dec_result_type decode_byte(input logic [BYTE_W-1:0] b);
      dec_result_type res;
      res = '0;
      if (b == END_OF_STRING) begin
         decoder_state = '0;
         return res;
      end
      if (decoder_state.dropping_rest)
         return res;
      if (decoder_state.bytes_pending != 2'd0) begin
         if (b[7:6] != CONT_TAG) begin
            decoder_state = '0;
            decoder_state.dropping_rest = 1'b1;
            return res;
         end
         decoder_state.partial_point = {decoder_state.partial_point[POINT_W-7:0], b[5:0]};
         decoder_state.bytes_pending = decoder_state.bytes_pending - 2'd1;
         if (decoder_state.bytes_pending == 2'd0) begin
            res.emit        = 1'b1;
            res.code_point  = decoder_state.partial_point;
            res.byte_length = decoder_state.sequence_length;
            decoder_state   = '0;
         end
         return res;
      end
      if (b <= ASCII_HI) begin
         res.emit        = 1'b1;
         res.code_point  = POINT_W'(b);
         res.byte_length = LEN_1;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         decoder_state.sequence_length = LEN_2;
         decoder_state.partial_point   = POINT_W'(b[4:0]);
         decoder_state.bytes_pending   = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         decoder_state.sequence_length = LEN_3;
         decoder_state.partial_point   = POINT_W'(b[3:0]);
         decoder_state.bytes_pending   = 2'd2;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         decoder_state.sequence_length = LEN_4;
         decoder_state.partial_point   = POINT_W'(b[2:0]);
         decoder_state.bytes_pending   = 2'd3;
      end else begin
         decoder_state = '0;
         decoder_state.dropping_rest = 1'b1;
      end
      return res;
   endfunction

   // Idle rate for the next stretch: 0 means no idling at all.
   function automatic int pick_rate();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 2;
         2: return 4;
         default: return 8;
      endcase
   endfunction

   // Build one string of random characters, now and then damaged.
   task automatic build_string();
      logic [BYTE_W-1:0] s [$];
      int nchars;
      int len;
      int k;
      nchars = $urandom_range(1, 8);
      for (int i = 0; i < nchars; i++) begin
         len = $urandom_range(1, 4);
         case (len)
            1: s.push_back(BYTE_W'($urandom_range(1, 127)));
            2: s.push_back({3'b110, 5'($urandom)});
            3: s.push_back({4'b1110, 4'($urandom)});
            default: s.push_back({5'b11110, 3'($urandom)});
         endcase
         for (int j = 1; j < len; j++)
            s.push_back({CONT_TAG, 6'($urandom)});
      end
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(0, s.size() - 1);
         case ($urandom_range(0, 2))
            0: s[k] = BYTE_W'($urandom_range(0, 255));
            1: s.delete(k);
            default:
               if ($urandom_range(0, 1) == 0)
                  s.insert(k, BYTE_W'($urandom_range(8'h80, 8'hBF)));
               else
                  s.insert(k, BYTE_W'($urandom_range(8'hF8, 8'hFF)));
         endcase
      end
      // Occasionally run two strings together without a terminator.
      if ($urandom_range(0, 15) != 0)
         s.push_back(END_OF_STRING);
      foreach (s[i])
         outgoing_text.push_back(s[i]);
      bytes_loaded += s.size();
      strings_built++;
   endtask

   always @(posedge clock) begin : byte_driver
      dec_result_type outcome;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            outcome = decode_byte(req_text_byte);
            bytes_taken++;
            if (outcome.emit)
               pending_points.push_back(outcome);
         end
         if (req_stall)
            input_stall_cycles++;
         tx_cycle++;
         if (tx_cycle % 64 == 0)
            tx_rate = pick_rate();
         tail_calm = random_loaded && (outgoing_text.size() < 100);
         // A stalled transaction holds its byte until taken.
         if (!(req_valid && req_stall)) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (!tail_calm && tx_rate != 0 && $urandom_range(1, tx_rate) == 1) begin
               tx_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (outgoing_text.size() != 0) begin
               req_valid     <= 1'b1;
               req_text_byte <= outgoing_text.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : point_receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0)
            rx_rate = pick_rate();
         // Once, well into the run, hold off long enough to back up the input.
         if (hold_left == 0 && !hold_done && bytes_taken >= 300) begin
            hold_left = 80;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_stall <= 1'b1;
         end else if (!tail_calm && rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
            rx_gap = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : point_monitor
      dec_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected code point, expected none, actual %06h length %0d",
                     $time, rsp_code_point, rsp_byte_length);
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_code_point !== want.code_point) begin
               mismatches++;
               $display("%0t: code_point mismatch, expected %06h, actual %06h",
                        $time, want.code_point, rsp_code_point);
            end
            if (rsp_byte_length !== want.byte_length) begin
               mismatches++;
               $display("%0t: byte_length mismatch, expected %0d, actual %0d",
                        $time, want.byte_length, rsp_byte_length);
            end
         end
      end
   end

   initial begin : stimulus
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_text[i])
         outgoing_text.push_back(opening_text[i]);
      bytes_loaded += $size(opening_text);
      strings_built += 4;

      // Pause the sender until the directed part has fully drained.
      do @(posedge clock); while (bytes_taken != bytes_loaded);
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      while (outgoing_text.size() < 925)
         build_string();
      random_loaded = 1'b1;

      do @(posedge clock); while (bytes_taken != bytes_loaded);
      guard = 0;
      while (pending_points.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_points.size() != 0) begin
         mismatches += pending_points.size();
         $display("%0t: %0d expected code points never arrived, expected 0, actual %0d",
                  $time, pending_points.size(), pending_points.size());
      end

      $display("summary: %0d bytes in %0d strings, %0d code points checked",
               bytes_taken, strings_built, points_checked);
      $display("summary: input stalled %0d cycles, long receiver hold-off %0s",
               input_stall_cycles, hold_done ? "done" : "missed");
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/u8sd_pkg.sv
rtl/u8sd_step.sv
rtl/utf8_stream_decoder.sv
tb/tb.sv
